>>> rtl/core/euler_to_quaternion_top_defines.svh
// ----------------------------------------------------------------------------
// euler_to_quaternion_top_defines
// Assertion macros shared by the euler to quaternion pipeline.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_TOP_DEFINES_SVH
`define EULER_TO_QUATERNION_TOP_DEFINES_SVH

// condition must hold on every clock edge outside reset
`define E2Q_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define E2Q_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/core/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg
// Types, constants and the arctangent table of the euler to quaternion block.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int FIELD_W            = 16;
  localparam int ANGLE_BITS_DEF     = 16;
  localparam int QUAT_FRAC_BITS_DEF = 14;

  localparam int CORDIC_STEPS = 32;
  localparam int STEP_IW      = $clog2(CORDIC_STEPS);
  localparam int UNIT_SHIFT   = 30;
  localparam int CORDIC_START = 652032874;  // inverse cordic gain in q30

  localparam int ZW     = 36;  // residual angle, 2^33 equals pi
  localparam int XYW    = 34;  // cordic vector
  localparam int TRIG_W = 32;  // q30 sine and cosine

  localparam int COMB_STAGES = 4;
  localparam int LATENCY     = 1 + CORDIC_STEPS + COMB_STAGES;

  typedef struct packed {
    logic signed [FIELD_W-1:0] yaw_angle;
    logic signed [FIELD_W-1:0] pitch_angle;
    logic signed [FIELD_W-1:0] roll_angle;
  } e2q_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] quat_w;
    logic signed [FIELD_W-1:0] quat_x;
    logic signed [FIELD_W-1:0] quat_y;
    logic signed [FIELD_W-1:0] quat_z;
  } e2q_out_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
  } trig_t;

  // atan(2^-i), 2^31 equals pi
  function automatic logic [31:0] atan_lut(input logic [STEP_IW-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/e2q_cordic.sv
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined rotation-mode cordic, one step per register stage, giving the
// q30 cosine and sine of half of one binary angle.
// ----------------------------------------------------------------------------
module e2q_cordic
  import e2q_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [FIELD_W-1:0] in_angle,
  output logic               out_vld,
  output trig_t              out_trig
);

  localparam int EXT_W  = (ANGLE_BITS > FIELD_W) ? ANGLE_BITS : FIELD_W;
  localparam int ZSHIFT = 33 - ANGLE_BITS;

  logic [EXT_W-1:0]            raw_ext;
  logic signed [ANGLE_BITS-1:0] ang;
  logic signed [ZW-1:0]         z0;

  logic                 vld_r [CORDIC_STEPS];
  logic signed [XYW-1:0] x_r  [CORDIC_STEPS];
  logic signed [XYW-1:0] y_r  [CORDIC_STEPS];
  logic signed [ZW-1:0]  z_r  [CORDIC_STEPS-1];

  // bits above the angle width are dropped, the rest sign extended
  assign raw_ext = EXT_W'(in_angle);
  assign ang     = raw_ext[ANGLE_BITS-1:0];
  assign z0      = ZW'(ang) <<< ZSHIFT;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    localparam logic signed [ZW-1:0] DA =
      {{(ZW-34){1'b0}}, atan_lut(STEP_IW'(i)), 2'b00};

    logic                  vld_in;
    logic signed [XYW-1:0] x_in;
    logic signed [XYW-1:0] y_in;
    logic signed [ZW-1:0]  z_in;
    logic signed [XYW-1:0] x_nxt;
    logic signed [XYW-1:0] y_nxt;

    if (i == 0) begin : g_first
      assign vld_in = in_vld;
      assign x_in   = XYW'(CORDIC_START);
      assign y_in   = '0;
      assign z_in   = z0;
    end else begin : g_next
      assign vld_in = vld_r[i-1];
      assign x_in   = x_r[i-1];
      assign y_in   = y_r[i-1];
      assign z_in   = z_r[i-1];
    end

    always_comb begin
      if (!z_in[ZW-1]) begin
        x_nxt = x_in - (y_in >>> i);
        y_nxt = y_in + (x_in >>> i);
      end else begin
        x_nxt = x_in + (y_in >>> i);
        y_nxt = y_in - (x_in >>> i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
      x_r[i] <= x_nxt;
      y_r[i] <= y_nxt;
    end

    // the last step leaves no residual angle to keep
    if (i < CORDIC_STEPS - 1) begin : g_z
      logic signed [ZW-1:0] z_nxt;
      assign z_nxt = z_in[ZW-1] ? (z_in + DA) : (z_in - DA);
      always_ff @(posedge clk) begin
        z_r[i] <= z_nxt;
      end
    end
  end

  assign out_vld    = vld_r[CORDIC_STEPS-1];
  assign out_trig.c = x_r[CORDIC_STEPS-1][TRIG_W-1:0];
  assign out_trig.s = y_r[CORDIC_STEPS-1][TRIG_W-1:0];

endmodule

>>> rtl/core/e2q_combine.sv
// ----------------------------------------------------------------------------
// e2q_combine
// Forms the zyx quaternion from the half-angle sines and cosines: pair
// products, triple products, sums, then rounding and saturation.
// ----------------------------------------------------------------------------
module e2q_combine
  import e2q_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_vld,
  input  trig_t    trig_yaw,
  input  trig_t    trig_pitch,
  input  trig_t    trig_roll,
  output logic     out_valid,
  output e2q_out_t out_data
);

  `include "euler_to_quaternion_top_defines.svh"

  localparam int SUM_W = TRIG_W + 1;
  localparam int SAT_W = SUM_W + 1;
  localparam int SH    = UNIT_SHIFT - QUAT_FRAC_BITS;

  localparam logic signed [SAT_W-1:0] HALF    = (SH > 0) ? (SAT_W'(1) <<< (SH - 1)) : '0;
  localparam logic signed [SAT_W-1:0] ONE     = SAT_W'(1) <<< QUAT_FRAC_BITS;
  localparam logic signed [SAT_W-1:0] NEG_ONE = -ONE;

  function automatic logic signed [TRIG_W-1:0] mulq(input logic signed [TRIG_W-1:0] a,
                                                    input logic signed [TRIG_W-1:0] b);
    logic signed [2*TRIG_W-1:0] p;
    p = a * b;
    return p[UNIT_SHIFT+TRIG_W-1:UNIT_SHIFT];
  endfunction

  // add half an lsb, floor shift, clamp to plus or minus one
  function automatic logic signed [SAT_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SAT_W-1:0] r;
    r = (SAT_W'(v) + HALF) >>> SH;
    if (r > ONE) begin
      r = ONE;
    end else if (r < NEG_ONE) begin
      r = NEG_ONE;
    end
    return r;
  endfunction

  // stage a: roll times pitch
  logic                     a_vld_r;
  logic signed [TRIG_W-1:0] rcpc_r, rsps_r, rspc_r, rcps_r, cy_r, sy_r;
  // stage b: times yaw
  logic                     b_vld_r;
  logic signed [TRIG_W-1:0] w1_r, w2_r, x1_r, x2_r, y1_r, y2_r, z1_r, z2_r;
  // stage c: sums
  logic                     c_vld_r;
  logic signed [SUM_W-1:0]  sum_w_r, sum_x_r, sum_y_r, sum_z_r;
  // stage d: rounded and saturated
  logic                     d_vld_r;
  logic signed [SAT_W-1:0]  qw_r, qx_r, qy_r, qz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end

    rcpc_r <= mulq(trig_roll.c, trig_pitch.c);
    rsps_r <= mulq(trig_roll.s, trig_pitch.s);
    rspc_r <= mulq(trig_roll.s, trig_pitch.c);
    rcps_r <= mulq(trig_roll.c, trig_pitch.s);
    cy_r   <= trig_yaw.c;
    sy_r   <= trig_yaw.s;

    w1_r <= mulq(rcpc_r, cy_r);
    w2_r <= mulq(rsps_r, sy_r);
    x1_r <= mulq(rspc_r, cy_r);
    x2_r <= mulq(rcps_r, sy_r);
    y1_r <= mulq(rcps_r, cy_r);
    y2_r <= mulq(rspc_r, sy_r);
    z1_r <= mulq(rcpc_r, sy_r);
    z2_r <= mulq(rsps_r, cy_r);

    sum_w_r <= SUM_W'(w1_r) + SUM_W'(w2_r);
    sum_x_r <= SUM_W'(x1_r) - SUM_W'(x2_r);
    sum_y_r <= SUM_W'(y1_r) + SUM_W'(y2_r);
    sum_z_r <= SUM_W'(z1_r) - SUM_W'(z2_r);

    qw_r <= round_sat(sum_w_r);
    qx_r <= round_sat(sum_x_r);
    qy_r <= round_sat(sum_y_r);
    qz_r <= round_sat(sum_z_r);
  end

  assign out_valid       = d_vld_r;
  assign out_data.quat_w = qw_r[FIELD_W-1:0];
  assign out_data.quat_x = qx_r[FIELD_W-1:0];
  assign out_data.quat_y = qy_r[FIELD_W-1:0];
  assign out_data.quat_z = qz_r[FIELD_W-1:0];

  `E2Q_ASSERT_IMPL(a_sat_bound, d_vld_r,
    (qw_r <= ONE) && (qw_r >= NEG_ONE) && (qx_r <= ONE) && (qx_r >= NEG_ONE) &&
    (qy_r <= ONE) && (qy_r >= NEG_ONE) && (qz_r <= ONE) && (qz_r >= NEG_ONE),
    "quaternion component outside plus or minus one")

endmodule

>>> rtl/core/euler_to_quaternion_top.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion_top
// Converts yaw, pitch and roll binary angles to a zyx unit quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   A word of three angles is taken on in_data at each clock edge where
//   start is high and busy is low. 2^(ANGLE_BITS-1) stands for pi.
//   busy is high only while rst_n is low; otherwise a word may be given
//   in every cycle.
//   Each word yields one result word on out_data, w x y z in signed
//   q1.QUAT_FRAC_BITS, flagged by a one-cycle out_valid pulse, in order.
//   From start to out_valid a word passes one input register,
//   32 cordic steps (one per stage, three angle lanes side by side) and
//   four stages of products, sums and rounding.
//   Throughput is one word per cycle; the depth is set by the cordic chain.
//   Synchronous reset clears all valid flags so no result is flagged
//   afterward until new words arrive; words in flight are dropped.
//   The receiver has no way to stall the output and must take each word
//   in the cycle out_valid is high.
// ----------------------------------------------------------------------------
module euler_to_quaternion_top
  import e2q_pkg::*;
#(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  e2q_in_t  in_data,
  output logic     out_valid,
  output e2q_out_t out_data
);

  `include "euler_to_quaternion_top_defines.svh"

  logic    in_vld_r;
  e2q_in_t in_r;

  logic  vld_yaw, vld_pitch, vld_roll;
  trig_t trig_yaw, trig_pitch, trig_roll;

  assign busy = !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
    in_r <= in_data;
  end

  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_yaw (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld_r),
    .in_angle (in_r.yaw_angle),
    .out_vld  (vld_yaw),
    .out_trig (trig_yaw)
  );

  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_pitch (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld_r),
    .in_angle (in_r.pitch_angle),
    .out_vld  (vld_pitch),
    .out_trig (trig_pitch)
  );

  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_roll (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld_r),
    .in_angle (in_r.roll_angle),
    .out_vld  (vld_roll),
    .out_trig (trig_roll)
  );

  e2q_combine #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_combine (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (vld_yaw),
    .trig_yaw   (trig_yaw),
    .trig_pitch (trig_pitch),
    .trig_roll  (trig_roll),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  `E2Q_ASSERT_ALWAYS(a_lane_sync, (vld_yaw == vld_pitch) && (vld_pitch == vld_roll),
    "cordic lanes out of step")

  `E2Q_ASSERT_IMPL(a_result_has_word, out_valid, $past(start && !busy, LATENCY),
    "result flagged without a word taken at the pipeline latency")

endmodule

>>> tb/euler_to_quaternion_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_top_test
// Sends yaw, pitch and roll words to the converter and checks every quaternion
// word against a bit-exact cordic and fixed-point product model kept here.
// ----------------------------------------------------------------------------
module euler_to_quaternion_top_test;
  import e2q_pkg::*;

  localparam int ANG_BITS   = ANGLE_BITS_DEF;
  localparam int FRAC_BITS  = QUAT_FRAC_BITS_DEF;
  localparam int STALL_MAX  = 1000;
  localparam int SHOW_MAX   = 10;

  logic     clk;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  e2q_in_t  in_data = '0;
  logic     busy;
  logic     out_valid;
  e2q_out_t out_data;

  // atan(2^-i), 2^31 equals pi
  longint arctan_q31 [0:31] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
    64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000
  };

  e2q_out_t quat_expected [$];
  int       words_sent    = 0;
  int       words_checked = 0;
  int       mismatches    = 0;
  int       stall_cycles  = 0;

  euler_to_quaternion_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cosine and sine of half the angle, q30
  function automatic void half_angle_trig(input logic signed [15:0] ang,
                                          output longint c, output longint s);
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    z = longint'(ang) * (64'sd1 <<< (33 - ANG_BITS));
    x = CORDIC_START;
    y = 0;
    for (int i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_q31[i] * 4;
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_q31[i] * 4;
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  // round half up to q1.14, clamp to plus or minus one
  function automatic logic [15:0] round_to_q14(input longint v);
    longint r;
    longint one;
    one = 64'sd1 <<< FRAC_BITS;
    r = (v + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[15:0];
  endfunction

  function automatic e2q_out_t predict_quat(input e2q_in_t a);
    longint cy, sy, cp, sp, cr, sr;
    e2q_out_t q;
    half_angle_trig(a.yaw_angle, cy, sy);
    half_angle_trig(a.pitch_angle, cp, sp);
    half_angle_trig(a.roll_angle, cr, sr);
    q.quat_w = round_to_q14(mul_q30(mul_q30(cr, cp), cy) + mul_q30(mul_q30(sr, sp), sy));
    q.quat_x = round_to_q14(mul_q30(mul_q30(sr, cp), cy) - mul_q30(mul_q30(cr, sp), sy));
    q.quat_y = round_to_q14(mul_q30(mul_q30(cr, sp), cy) + mul_q30(mul_q30(sr, cp), sy));
    q.quat_z = round_to_q14(mul_q30(mul_q30(cr, cp), sy) - mul_q30(mul_q30(sr, sp), cy));
    return q;
  endfunction

  function automatic e2q_in_t angles_of(input int yaw, input int pitch, input int roll);
    e2q_in_t a;
    a.yaw_angle   = yaw[15:0];
    a.pitch_angle = pitch[15:0];
    a.roll_angle  = roll[15:0];
    return a;
  endfunction

  // mostly uniform, sometimes a corner angle
  function automatic logic [15:0] pick_angle();
    logic [15:0] v;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 6))
        0:       v = 16'h0000;
        1:       v = 16'h8000;
        2:       v = 16'h7FFF;
        3:       v = 16'h4000;
        4:       v = 16'hC000;
        5:       v = 16'h0001;
        default: v = 16'hFFFF;
      endcase
    end else begin
      v = 16'($urandom_range(0, 65535));
    end
    return v;
  endfunction

  // start stays high across back-to-back words
  task automatic send_angles(input e2q_in_t angles, input bit paced);
    int unsigned gap;
    gap = paced ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= angles;
    do @(posedge clk); while (busy !== 1'b0);
    quat_expected.push_back(predict_quat(angles));
    words_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (quat_expected.size() != 0) @(posedge clk);
  endtask

  task automatic test_corner_angles();
    send_angles(angles_of(0, 0, 0), 1'b1);
    send_angles(angles_of(-32768, 0, 0), 1'b1);
    send_angles(angles_of(0, -32768, 0), 1'b1);
    send_angles(angles_of(0, 0, -32768), 1'b1);
    send_angles(angles_of(-32768, -32768, -32768), 1'b1);
    send_angles(angles_of(32767, 32767, 32767), 1'b1);
    send_angles(angles_of(16384, 0, 0), 1'b1);
    send_angles(angles_of(0, 16384, 0), 1'b1);
    send_angles(angles_of(0, 0, 16384), 1'b1);
    send_angles(angles_of(-16384, -16384, -16384), 1'b1);
    send_angles(angles_of(16384, 16384, 16384), 1'b1);
    send_angles(angles_of(1, -1, 1), 1'b1);
    send_angles(angles_of(-1, 1, -1), 1'b1);
    send_angles(angles_of(32767, -32768, 0), 1'b1);
    send_angles(angles_of(-32768, 32767, 16384), 1'b1);
    send_angles(angles_of(8192, -8192, 24576), 1'b1);
    send_angles(angles_of(-24576, 12345, -30000), 1'b1);
    send_angles(angles_of(21845, -21845, 10923), 1'b1);
  endtask

  task automatic test_random_paced(input int count);
    for (int n = 0; n < count; n++)
      send_angles(angles_of(pick_angle(), pick_angle(), pick_angle()), 1'b1);
  endtask

  // full rate, no gaps between words
  task automatic test_full_rate(input int count);
    for (int n = 0; n < count; n++)
      send_angles(angles_of(pick_angle(), pick_angle(), pick_angle()), 1'b0);
  endtask

  // sender stops until the pipeline has emptied, then resumes
  task automatic test_drain_and_resume(input int rounds, input int per_round);
    for (int r = 0; r < rounds; r++) begin
      for (int n = 0; n < per_round; n++)
        send_angles(angles_of(pick_angle(), pick_angle(), pick_angle()), r[0]);
      wait_drained();
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    e2q_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (quat_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("unexpected quaternion word %h at %0t", out_data, $realtime);
      end else begin
        want = quat_expected.pop_front();
        words_checked++;
        if (out_data.quat_w !== want.quat_w || out_data.quat_x !== want.quat_x ||
            out_data.quat_y !== want.quat_y || out_data.quat_z !== want.quat_z) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("word %0d: expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
                     words_checked, want.quat_w, want.quat_x, want.quat_y, want.quat_z,
                     out_data.quat_w, out_data.quat_x, out_data.quat_y, out_data.quat_z);
        end
      end
    end
  end

  // no word moving in either direction for too long
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("timeout after %0d idle cycles, %0d words outstanding",
               stall_cycles, quat_expected.size());
      $display("euler_to_quaternion_top: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_angles();
    test_random_paced(630);
    test_full_rate(200);
    test_drain_and_resume(4, 50);

    wait_drained();
    repeat (LATENCY + 8) @(posedge clk);

    if (quat_expected.size() != 0) mismatches++;
    $display("sent %0d angle words (corners, random paced, full rate, drain pauses)",
             words_sent);
    $display("checked %0d quaternion words, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("euler_to_quaternion_top: match");
    end else begin
      $display("euler_to_quaternion_top: mismatch");
    end
    $finish;
  end

endmodule
